// ===== rtl/wpsv_pkg.sv =====
package wpsv_pkg;

  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagData = 32'h6174_6164;

  localparam logic [127:0] FmtPcm16kMono = {64'h0010_0002_0000_7D00, 64'h0000_3E80_0001_0001};

  localparam logic [31:0] FmtMinSize = 32'd16;

  localparam logic [10:0] TolMin     = 11'd250;
  localparam logic [10:0] TolMax     = 11'd2000;
  localparam logic [31:0] TolLowExp  = 32'd50000;
  localparam logic [31:0] TolHighExp = 32'd400200;
  localparam logic [31:0] TolRecip   = 32'd83887;
  localparam int unsigned TolShift   = 21;

  localparam logic [32:0] DurRound = 33'd16;

  typedef enum logic [3:0] {
    StOk           = 4'd0,
    StBadExpected  = 4'd1,
    StNotWave      = 4'd2,
    StSizeMismatch = 4'd3,
    StOverrun      = 4'd4,
    StBadFmt       = 4'd5,
    StTwoData      = 4'd6,
    StMissing      = 4'd7,
    StFormat       = 4'd8,
    StSampleSize   = 4'd9,
    StDuration     = 4'd10
  } status_e;

  typedef struct packed {
    logic [32:0] total;
    logic [32:0] riff_end;
    status_e     first_err;
    logic        done;
    logic [1:0]  seen;
    logic        fmt_ok;
    logic [32:0] data_start;
    logic [31:0] data_len;
  } walk_t;

endpackage

// ===== rtl/wpsv_if.sv =====
interface wpsv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       is_last;

  modport source (output valid, output file_byte, output is_last, input ready);
  modport sink (input valid, input file_byte, input is_last, output ready);
endinterface

interface wpsv_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [32:0] data_offset;
  logic [31:0] data_size;
  logic [17:0] duration_ms;
  logic [10:0] tolerance_ms;

  modport source (
    output valid, output status, output data_offset, output data_size,
    output duration_ms, output tolerance_ms, input ready
  );
  modport sink (
    input valid, input status, input data_offset, input data_size,
    input duration_ms, input tolerance_ms, output ready
  );
endinterface

// ===== rtl/wpsv_tol_calc.sv =====
module wpsv_tol_calc (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] exp_i,
  output logic [10:0] tol_o
);

  logic [31:0] prod;
  logic [10:0] tol_d, tol_q;

  assign prod = 32'(exp_i[18:3]) * wpsv_pkg::TolRecip;

  always_comb begin
    priority if (exp_i < wpsv_pkg::TolLowExp) begin
      tol_d = wpsv_pkg::TolMin;
    end else if (exp_i >= wpsv_pkg::TolHighExp) begin
      tol_d = wpsv_pkg::TolMax;
    end else begin
      tol_d = prod[wpsv_pkg::TolShift +: 11];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= wpsv_pkg::TolMin;
    end else begin
      tol_q <= tol_d;
    end
  end

  assign tol_o = tol_q;

endmodule

// ===== rtl/wpsv_chunk_walk.sv =====
module wpsv_chunk_walk (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  output wpsv_pkg::walk_t     walk_o
);

  localparam logic [2:0] PhHeader   = 3'd0;
  localparam logic [2:0] PhChunkHdr = 3'd1;
  localparam logic [2:0] PhFmt      = 3'd2;
  localparam logic [2:0] PhSkip     = 3'd3;
  localparam logic [2:0] PhDone     = 3'd4;

  logic [2:0]        phase_q, phase_d;
  logic [32:0]       pos_q, pos_d;
  logic [32:0]       riff_end_q, riff_end_d;
  logic [32:0]       left_q, left_d;
  logic [32:0]       dstart_q, dstart_d;
  logic [31:0]       dlen_q, dlen_d;
  logic [63:0]       hdr_q, hdr_d;
  logic [4:0]        fcnt_q, fcnt_d;
  logic [15:0][7:0]  fmt_q, fmt_d;
  logic [1:0]        seen_q, seen_d;
  wpsv_pkg::status_e err_q, err_d;

  logic [63:0] hdr_sh;
  logic [33:0] next_pos;
  logic [32:0] size_pad;
  logic [34:0] chunk_end;
  logic [32:0] left_dec;
  logic        bnd_short;
  logic        bnd_missing;
  logic [2:0]  bnd_phase;

  assign hdr_sh      = {byte_i, hdr_q[63:8]};
  assign next_pos    = {1'b0, pos_q} + 34'd1;
  assign size_pad    = {1'b0, hdr_sh[63:32]} + {32'b0, hdr_sh[32]};
  assign chunk_end   = {1'b0, next_pos} + {2'b0, size_pad};
  assign left_dec    = left_q - 33'd1;
  assign bnd_short   = ({1'b0, next_pos} + 35'd8) > {2'b0, riff_end_q};
  assign bnd_missing = bnd_short && (next_pos != {1'b0, riff_end_q});
  assign bnd_phase   = bnd_short ? PhDone : PhChunkHdr;

  always_comb begin
    phase_d    = phase_q;
    pos_d      = (pos_q == '1) ? pos_q : next_pos[32:0];
    riff_end_d = riff_end_q;
    left_d     = left_q;
    dstart_d   = dstart_q;
    dlen_d     = dlen_q;
    hdr_d      = hdr_q;
    fcnt_d     = fcnt_q;
    fmt_d      = fmt_q;
    seen_d     = seen_q;
    err_d      = err_q;

    unique case (phase_q)
      PhHeader: begin
        hdr_d = hdr_sh;
        if (pos_q == 33'd7) begin
          if (hdr_sh[31:0] != wpsv_pkg::TagRiff) begin
            err_d   = wpsv_pkg::StNotWave;
            phase_d = PhDone;
          end else begin
            riff_end_d = 33'd8 + {1'b0, hdr_sh[63:32]};
          end
        end else if (pos_q == 33'd11) begin
          if (hdr_sh[63:32] != wpsv_pkg::TagWave) begin
            err_d   = wpsv_pkg::StNotWave;
            phase_d = PhDone;
          end else begin
            phase_d = bnd_phase;
            left_d  = 33'd8;
            if (bnd_missing) begin
              err_d = wpsv_pkg::StMissing;
            end
          end
        end
      end
      PhChunkHdr: begin
        hdr_d  = hdr_sh;
        left_d = left_dec;
        if (left_dec == '0) begin
          if (chunk_end > {2'b0, riff_end_q}) begin
            err_d   = wpsv_pkg::StOverrun;
            phase_d = PhDone;
          end else if (hdr_sh[31:0] == wpsv_pkg::TagFmt) begin
            if (seen_q[0] || hdr_sh[63:32] < wpsv_pkg::FmtMinSize) begin
              err_d   = wpsv_pkg::StBadFmt;
              phase_d = PhDone;
            end else begin
              seen_d[0] = 1'b1;
              phase_d   = PhFmt;
              left_d    = size_pad;
              fcnt_d    = '0;
            end
          end else if (hdr_sh[31:0] == wpsv_pkg::TagData && seen_q[1]) begin
            err_d   = wpsv_pkg::StTwoData;
            phase_d = PhDone;
          end else begin
            if (hdr_sh[31:0] == wpsv_pkg::TagData) begin
              seen_d[1] = 1'b1;
              dstart_d  = next_pos[32:0];
              dlen_d    = hdr_sh[63:32];
            end
            if (size_pad == '0) begin
              phase_d = bnd_phase;
              left_d  = 33'd8;
              if (bnd_missing) begin
                err_d = wpsv_pkg::StMissing;
              end
            end else begin
              phase_d = PhSkip;
              left_d  = size_pad;
            end
          end
        end
      end
      PhFmt: begin
        if (!fcnt_q[4]) begin
          fmt_d[fcnt_q[3:0]] = byte_i;
          fcnt_d             = fcnt_q + 5'd1;
        end
        left_d = left_dec;
        if (left_dec == '0) begin
          phase_d = bnd_phase;
          left_d  = 33'd8;
          if (bnd_missing) begin
            err_d = wpsv_pkg::StMissing;
          end
        end
      end
      PhSkip: begin
        left_d = left_dec;
        if (left_dec == '0) begin
          phase_d = bnd_phase;
          left_d  = 33'd8;
          if (bnd_missing) begin
            err_d = wpsv_pkg::StMissing;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHeader;
      pos_q      <= '0;
      riff_end_q <= '0;
      left_q     <= '0;
      dstart_q   <= '0;
      dlen_q     <= '0;
      hdr_q      <= '0;
      fcnt_q     <= '0;
      fmt_q      <= '0;
      seen_q     <= '0;
      err_q      <= wpsv_pkg::StOk;
    end else if (step_i) begin
      if (last_i) begin
        phase_q    <= PhHeader;
        pos_q      <= '0;
        riff_end_q <= '0;
        left_q     <= '0;
        dstart_q   <= '0;
        dlen_q     <= '0;
        hdr_q      <= '0;
        fcnt_q     <= '0;
        fmt_q      <= '0;
        seen_q     <= '0;
        err_q      <= wpsv_pkg::StOk;
      end else begin
        phase_q    <= phase_d;
        pos_q      <= pos_d;
        riff_end_q <= riff_end_d;
        left_q     <= left_d;
        dstart_q   <= dstart_d;
        dlen_q     <= dlen_d;
        hdr_q      <= hdr_d;
        fcnt_q     <= fcnt_d;
        fmt_q      <= fmt_d;
        seen_q     <= seen_d;
        err_q      <= err_d;
      end
    end
  end

  always_comb begin
    walk_o.total      = pos_d;
    walk_o.riff_end   = riff_end_d;
    walk_o.first_err  = err_d;
    walk_o.done       = (phase_d == PhDone);
    walk_o.seen       = seen_d;
    walk_o.fmt_ok     = (fmt_d == wpsv_pkg::FmtPcm16kMono);
    walk_o.data_start = dstart_q;
    walk_o.data_len   = dlen_q;
  end

endmodule

// ===== rtl/wav_pcm_stream_validator_unit.sv =====
// Channel | Dir | Payload                                              | Handshake
// pcm_i   | in  | file_byte[7:0], is_last                              | valid/ready
// res_o   | out | status[3:0], data_offset[32:0], data_size[31:0],     | valid/ready
//         |     | duration_ms[17:0], tolerance_ms[10:0]                |
// cfg     | in  | cfg_wdata_i[31:0] (expected duration, ms)            | cfg_we_i
//
// One byte per cycle unless pcm_i stalls; a result holds the verdict on its last byte.
// The chunk walk and the verdict sit between the input register and the result register.
// pcm_i stalls only while a last byte waits behind an untaken result.
// Reset clears the walk state and the expected duration; after each verdict the walk restarts.
// A write loads the expected duration register; the tolerance is registered from it.
module wav_pcm_stream_validator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  wpsv_in_if.sink            pcm_i,
  wpsv_out_if.source         res_o
);

  logic [31:0] exp_q;
  logic [10:0] tol;

  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_last_q;

  logic        out_free;
  logic        advance;
  logic        step;

  wpsv_pkg::walk_t   walk;
  wpsv_pkg::status_e st;

  logic signed [37:0] diff;
  logic signed [37:0] tol_bytes;
  logic signed [37:0] tol_bytes_neg;
  logic               range_bad;
  logic [32:0]        dur_sum;
  logic               fill;

  logic        res_valid_q;
  logic [3:0]  res_status_q;
  logic [32:0] res_offset_q;
  logic [31:0] res_size_q;
  logic [17:0] res_dur_q;
  logic [10:0] res_tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= '0;
    end else if (cfg_we_i) begin
      exp_q <= cfg_wdata_i;
    end
  end

  wpsv_tol_calc u_tol_calc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .exp_i  (exp_q),
    .tol_o  (tol)
  );

  assign out_free    = !res_valid_q || res_o.ready;
  assign advance     = !s1_last_q || out_free;
  assign step        = s1_valid_q && advance;
  assign pcm_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_byte_q  <= '0;
      s1_last_q  <= 1'b0;
    end else if (pcm_i.ready) begin
      s1_valid_q <= pcm_i.valid;
      s1_byte_q  <= pcm_i.file_byte;
      s1_last_q  <= pcm_i.is_last;
    end
  end

  wpsv_chunk_walk u_chunk_walk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (s1_byte_q),
    .last_i (s1_last_q),
    .walk_o (walk)
  );

  assign diff          = $signed({6'b0, walk.data_len}) - $signed({1'b0, exp_q, 5'b0});
  assign tol_bytes     = $signed({22'b0, tol, 5'b0}) + 38'sd2;
  assign tol_bytes_neg = -tol_bytes;
  assign range_bad     = (diff > tol_bytes) || (diff < tol_bytes_neg);
  assign dur_sum       = {1'b0, walk.data_len} + wpsv_pkg::DurRound;

  always_comb begin
    priority if (exp_q == '0) begin
      st = wpsv_pkg::StBadExpected;
    end else if (walk.total < 33'd12 || walk.first_err == wpsv_pkg::StNotWave) begin
      st = wpsv_pkg::StNotWave;
    end else if (walk.riff_end != walk.total) begin
      st = wpsv_pkg::StSizeMismatch;
    end else if (walk.first_err != wpsv_pkg::StOk) begin
      st = walk.first_err;
    end else if (!walk.done || walk.seen != 2'b11) begin
      st = wpsv_pkg::StMissing;
    end else if (!walk.fmt_ok) begin
      st = wpsv_pkg::StFormat;
    end else if (walk.data_len == '0 || walk.data_len[0]) begin
      st = wpsv_pkg::StSampleSize;
    end else if (range_bad) begin
      st = wpsv_pkg::StDuration;
    end else begin
      st = wpsv_pkg::StOk;
    end
  end

  assign fill = (st == wpsv_pkg::StOk) || (st == wpsv_pkg::StDuration);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_free) begin
      res_valid_q <= step && s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && s1_last_q) begin
      res_status_q <= st;
      res_offset_q <= fill ? walk.data_start : '0;
      res_size_q   <= fill ? walk.data_len : '0;
      res_dur_q    <= fill ? dur_sum[22:5] : '0;
      res_tol_q    <= fill ? tol : '0;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.status       = res_status_q;
  assign res_o.data_offset  = res_offset_q;
  assign res_o.data_size    = res_size_q;
  assign res_o.duration_ms  = res_dur_q;
  assign res_o.tolerance_ms = res_tol_q;

endmodule

// ===== rtl/wpsv_checker.sv =====
module wpsv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [3:0]  status_i,
  input logic [32:0] data_offset_i,
  input logic [31:0] data_size_i,
  input logic [17:0] duration_ms_i,
  input logic [10:0] tolerance_ms_i
);

  logic filled;

  assign filled = (status_i == wpsv_pkg::StOk) || (status_i == wpsv_pkg::StDuration);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(status_i) && $stable(data_offset_i) &&
      $stable(data_size_i) && $stable(duration_ms_i) && $stable(tolerance_ms_i))
    else $error("result changed while stalled");

  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> res_valid_i && !res_ready_i)
    else $error("input stalled without output backpressure");

  a_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !filled |-> data_offset_i == '0 && data_size_i == '0 &&
      duration_ms_i == '0 && tolerance_ms_i == '0)
    else $error("fields set on an error verdict");

  a_tol_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && filled |-> tolerance_ms_i >= wpsv_pkg::TolMin &&
      tolerance_ms_i <= wpsv_pkg::TolMax)
    else $error("tolerance out of range");

endmodule

bind wav_pcm_stream_validator_unit wpsv_checker u_wpsv_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (pcm_i.ready),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .status_i       (res_o.status),
  .data_offset_i  (res_o.data_offset),
  .data_size_i    (res_o.data_size),
  .duration_ms_i  (res_o.duration_ms),
  .tolerance_ms_i (res_o.tolerance_ms)
);
